// File: rtl/hsb_pkg.sv
// hsb_pkg: shared types and constants for the hsv saturation boost block
// used by hsb_analyze and hsv_saturation_boost; depends on nothing
package hsb_pkg;

   // saturation gain register, unsigned Q2.8
   localparam int GAIN_W = 10;
   localparam int GAIN_FRAC = 8;
   localparam logic [GAIN_W-1:0] GAIN_ONE = 10'd256;
   localparam logic [GAIN_W-1:0] GAIN_MAX = 10'd768;

   // how one output channel is rebuilt
   typedef enum logic [1:0] {
      SEL_LOW  = 2'd0,  // min channel: floor value
      SEL_HIGH = 2'd1,  // max channel: floor plus chroma
      SEL_MID  = 2'd2,  // middle channel: floor plus scaled offset
      SEL_PASS = 2'd3   // unit gain or grey pixel: input copied
   } sel_type;

endpackage

// File: rtl/hsb_analyze.sv
// hsb_analyze: front four pipeline stages, from the rgb pixel to the new chroma,
// the floor value and the numerator and divisor of the middle channel
// depends on hsb_pkg
module hsb_analyze import hsb_pkg::*; #(
   parameter int W = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  logic            in_valid,
   input  logic [W-1:0]    red_i,
   input  logic [W-1:0]    green_i,
   input  logic [W-1:0]    blue_i,
   input  logic [W-1:0]    alpha_i,
   input  logic [GAIN_W-1:0] gain_i,
   output logic            out_valid,
   output logic [2*W-1:0]  num_o,
   output logic [W-1:0]    den_o,
   output logic [W-1:0]    chroma_o,
   output logic [W-1:0]    floor_o,
   output logic [3:0][W-1:0] pix_o,
   output sel_type [2:0]   sel_o
);

   localparam int SUM_W = W + 2;
   localparam int PROD_W = W + GAIN_W;
   localparam int SCL_W = PROD_W - GAIN_FRAC;

   // stage 1: max, min and clamped gain
   logic [W-1:0]      hi_rg, hi_c, lo_rg, lo_c;
   logic [GAIN_W-1:0] gain_c;
   logic              valid1_ff;
   logic [3:0][W-1:0] pix1_ff;
   logic [W-1:0]      hi1_ff, lo1_ff;
   logic [GAIN_W-1:0] gain1_ff;

   always_comb begin
      hi_rg = (red_i >= green_i) ? red_i : green_i;
      hi_c = (hi_rg >= blue_i) ? hi_rg : blue_i;
      lo_rg = (red_i <= green_i) ? red_i : green_i;
      lo_c = (lo_rg <= blue_i) ? lo_rg : blue_i;
      if (gain_i < GAIN_ONE) begin
         gain_c = GAIN_ONE;
      end else if (gain_i > GAIN_MAX) begin
         gain_c = GAIN_MAX;
      end else begin
         gain_c = gain_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
      end
      if (enable) begin
         pix1_ff <= {alpha_i, blue_i, green_i, red_i};
         hi1_ff <= hi_c;
         lo1_ff <= lo_c;
         gain1_ff <= gain_c;
      end
   end

   // stage 2: delta, middle offset, delta times gain, channel roles
   logic [W-1:0]      delta_c, mid_c, off_c;
   logic [SUM_W-1:0]  sum_c;
   logic [PROD_W-1:0] prod_c;
   logic              pass_c;
   sel_type [2:0]     sel_c;
   logic              valid2_ff;
   logic [3:0][W-1:0] pix2_ff;
   logic [W-1:0]      hi2_ff, delta2_ff, off2_ff;
   logic [PROD_W-1:0] prod2_ff;
   sel_type [2:0]     sel2_ff;

   always_comb begin
      delta_c = hi1_ff - lo1_ff;
      sum_c = SUM_W'(pix1_ff[0]) + SUM_W'(pix1_ff[1]) + SUM_W'(pix1_ff[2]);
      mid_c = W'(sum_c - SUM_W'(hi1_ff) - SUM_W'(lo1_ff));
      off_c = mid_c - lo1_ff;
      prod_c = PROD_W'(delta_c) * PROD_W'(gain1_ff);
      pass_c = (gain1_ff == GAIN_ONE) || (delta_c == '0);
      for (int i = 0; i < 3; i++) begin
         if (pass_c) begin
            sel_c[i] = SEL_PASS;
         end else if (pix1_ff[i] == lo1_ff) begin
            sel_c[i] = SEL_LOW;
         end else if (pix1_ff[i] == hi1_ff) begin
            sel_c[i] = SEL_HIGH;
         end else begin
            sel_c[i] = SEL_MID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (enable) begin
         valid2_ff <= valid1_ff;
      end
      if (enable) begin
         pix2_ff <= pix1_ff;
         hi2_ff <= hi1_ff;
         delta2_ff <= delta_c;
         off2_ff <= off_c;
         prod2_ff <= prod_c;
         sel2_ff <= sel_c;
      end
   end

   // stage 3: new chroma capped at value, floor = value - chroma
   logic [SCL_W-1:0]  scaled_c;
   logic [W-1:0]      chroma_c, floor_c;
   logic              valid3_ff;
   logic [3:0][W-1:0] pix3_ff;
   logic [W-1:0]      delta3_ff, off3_ff, chroma3_ff, floor3_ff;
   sel_type [2:0]     sel3_ff;

   always_comb begin
      scaled_c = prod2_ff[PROD_W-1:GAIN_FRAC];
      chroma_c = (scaled_c > SCL_W'(hi2_ff)) ? hi2_ff : scaled_c[W-1:0];
      floor_c = hi2_ff - chroma_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else if (enable) begin
         valid3_ff <= valid2_ff;
      end
      if (enable) begin
         pix3_ff <= pix2_ff;
         delta3_ff <= delta2_ff;
         off3_ff <= off2_ff;
         chroma3_ff <= chroma_c;
         floor3_ff <= floor_c;
         sel3_ff <= sel2_ff;
      end
   end

   // stage 4: numerator chroma times middle offset
   logic [2*W-1:0]    num_c;
   logic              valid4_ff;
   logic [3:0][W-1:0] pix4_ff;
   logic [W-1:0]      delta4_ff, chroma4_ff, floor4_ff;
   logic [2*W-1:0]    num4_ff;
   sel_type [2:0]     sel4_ff;

   assign num_c = (2*W)'(chroma3_ff) * (2*W)'(off3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else if (enable) begin
         valid4_ff <= valid3_ff;
      end
      if (enable) begin
         pix4_ff <= pix3_ff;
         delta4_ff <= delta3_ff;
         chroma4_ff <= chroma3_ff;
         floor4_ff <= floor3_ff;
         num4_ff <= num_c;
         sel4_ff <= sel3_ff;
      end
   end

   assign out_valid = valid4_ff;
   assign num_o = num4_ff;
   assign den_o = delta4_ff;
   assign chroma_o = chroma4_ff;
   assign floor_o = floor4_ff;
   assign pix_o = pix4_ff;
   assign sel_o = sel4_ff;

   // the quotient must fit in one channel for any boosted item
   assert property (@(posedge clock) disable iff (reset)
      valid4_ff && (sel4_ff[0] != SEL_PASS) |-> num4_ff[2*W-1:W] < delta4_ff)
      else $error("hsb_analyze: numerator too large for divisor");

   // chroma plus floor rebuilds the max channel
   assert property (@(posedge clock) disable iff (reset)
      valid3_ff |-> (floor3_ff + chroma3_ff) >= floor3_ff)
      else $error("hsb_analyze: floor plus chroma wraps");

endmodule

// File: rtl/hsb_div_pipe.sv
// hsb_div_pipe: pipelined restoring divider, one quotient bit per stage,
// with a side payload that travels alongside; no package dependency
module hsb_div_pipe #(
   parameter int W = 12,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [2*W-1:0]    num_i,
   input  logic [W-1:0]      den_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic              out_valid,
   output logic [W-1:0]      quo_o,
   output logic [SIDE_W-1:0] side_o
);

   // stage k inputs; index 0 comes from the ports
   logic [W-1:0]      rem_s   [0:W];
   logic [W-1:0]      shf_s   [0:W];
   logic [W-1:0]      den_s   [0:W];
   logic [SIDE_W-1:0] side_s  [0:W];
   logic              valid_s [0:W];

   // upper half is the starting remainder, lower half shifts in
   assign rem_s[0] = num_i[2*W-1:W];
   assign shf_s[0] = num_i[W-1:0];
   assign den_s[0] = den_i;
   assign side_s[0] = side_i;
   assign valid_s[0] = in_valid;

   for (genvar k = 0; k < W; k++) begin : g_step
      logic [W:0]        trial_c, diff_c;
      logic              fits_c;
      logic [W-1:0]      rem_ff, shf_ff, den_ff;
      logic [SIDE_W-1:0] side_ff;
      logic              valid_ff;

      // trial subtract of the divisor from the shifted remainder
      always_comb begin
         trial_c = {rem_s[k], shf_s[k][W-1]};
         diff_c = trial_c - {1'b0, den_s[k]};
         fits_c = trial_c >= {1'b0, den_s[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (enable) begin
            valid_ff <= valid_s[k];
         end
         if (enable) begin
            rem_ff <= fits_c ? diff_c[W-1:0] : trial_c[W-1:0];
            shf_ff <= {shf_s[k][W-2:0], fits_c};
            den_ff <= den_s[k];
            side_ff <= side_s[k];
         end
      end

      assign rem_s[k+1] = rem_ff;
      assign shf_s[k+1] = shf_ff;
      assign den_s[k+1] = den_ff;
      assign side_s[k+1] = side_ff;
      assign valid_s[k+1] = valid_ff;
   end

   assign out_valid = valid_s[W];
   assign quo_o = shf_s[W];
   assign side_o = side_s[W];

   // restoring step keeps the remainder below the divisor
   assert property (@(posedge clock) disable iff (reset)
      valid_s[W] && (den_s[W] != '0) |-> rem_s[W] < den_s[W])
      else $error("hsb_div_pipe: remainder not below divisor");

endmodule

// File: rtl/hsv_saturation_boost.sv
// hsv_saturation_boost: raises hsv saturation of an rgba pixel stream
// pipeline: four analysis stages, one divider stage per
//   quotient bit of the middle channel, one output register
// throughput one item per cycle; a stalled output freezes the whole pipeline
// reset clears all valid bits and sets the gain register to 1.0 (256)
// depends on hsb_pkg, hsb_analyze, hsb_div_pipe
module hsv_saturation_boost import hsb_pkg::*; #(
   parameter int CHANNEL_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // red_in, green_in, blue_in, alpha_in from bit 0 up, zero padded
   input  logic [((4*CHANNEL_BITS+7)/8)*8-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // red_out, green_out, blue_out, alpha_out from bit 0 up, zero padded
   output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic                       csr_wen,
   input  logic [GAIN_W-1:0]          csr_wdata
);

   localparam int W = CHANNEL_BITS;
   localparam int DATA_W = ((4*CHANNEL_BITS+7)/8)*8;
   localparam int SIDE_W = 6*W + 6;

   // gain register
   logic [GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_ONE;
      end else if (csr_wen) begin
         gain_ff <= csr_wdata;
      end
   end

   // whole pipeline advances unless the output item is held
   logic enable;
   logic rsp_valid_ff;

   assign enable = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable;

   // analysis stages
   logic              an_valid;
   logic [2*W-1:0]    an_num;
   logic [W-1:0]      an_den, an_chroma, an_floor;
   logic [3:0][W-1:0] an_pix;
   sel_type [2:0]     an_sel;

   hsb_analyze #(.W(W)) u_analyze (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .red_i     (req_tdata[0*W +: W]),
      .green_i   (req_tdata[1*W +: W]),
      .blue_i    (req_tdata[2*W +: W]),
      .alpha_i   (req_tdata[3*W +: W]),
      .gain_i    (gain_ff),
      .out_valid (an_valid),
      .num_o     (an_num),
      .den_o     (an_den),
      .chroma_o  (an_chroma),
      .floor_o   (an_floor),
      .pix_o     (an_pix),
      .sel_o     (an_sel)
   );

   // divider for the middle channel, rest of the item rides along
   logic              dv_valid;
   logic [W-1:0]      dv_quo;
   logic [SIDE_W-1:0] side_in, side_out;

   assign side_in = {an_pix, an_sel, an_floor, an_chroma};

   hsb_div_pipe #(.W(W), .SIDE_W(SIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (an_valid),
      .num_i     (an_num),
      .den_i     (an_den),
      .side_i    (side_in),
      .out_valid (dv_valid),
      .quo_o     (dv_quo),
      .side_o    (side_out)
   );

   // rebuild each channel from its role
   logic [W-1:0]      dv_chroma, dv_floor;
   sel_type [2:0]     dv_sel;
   logic [3:0][W-1:0] dv_pix;
   logic [2:0][W-1:0] chan_c;
   logic [DATA_W-1:0] rsp_data_in;
   logic [DATA_W-1:0] rsp_data_ff;

   always_comb begin
      dv_chroma = side_out[W-1:0];
      dv_floor = side_out[2*W-1:W];
      dv_pix = side_out[SIDE_W-1:2*W+6];
      for (int i = 0; i < 3; i++) begin
         dv_sel[i] = sel_type'(side_out[2*W+2*i +: 2]);
         unique case (dv_sel[i])
            SEL_LOW:  chan_c[i] = dv_floor;
            SEL_HIGH: chan_c[i] = dv_floor + dv_chroma;
            SEL_MID:  chan_c[i] = dv_floor + dv_quo;
            SEL_PASS: chan_c[i] = dv_pix[i];
            default:  chan_c[i] = dv_pix[i];
         endcase
      end
      rsp_data_in = DATA_W'({dv_pix[3], chan_c[2], chan_c[1], chan_c[0]});
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dv_valid;
      end
      if (enable) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // no item leaves right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("hsv_saturation_boost: output valid after reset");

   // the middle channel never passes the max channel
   assert property (@(posedge clock) disable iff (reset)
      dv_valid && (dv_sel[0] == SEL_MID || dv_sel[1] == SEL_MID ||
                   dv_sel[2] == SEL_MID) |-> dv_quo <= dv_chroma)
      else $error("hsv_saturation_boost: middle quotient above chroma");

endmodule
